// ===== hdl/lkvc_pkg.sv =====
package lkvc_pkg;

	localparam int DEPTH  = 16;
	localparam int SLOT_W = $clog2(DEPTH);
	localparam int CNT_W  = $clog2(DEPTH + 1);
	localparam int KEY_W  = 32;
	localparam int VAL_W  = 32;
	localparam int CAP_W  = 5;

	localparam logic [CAP_W-1:0] CAP_RESET = CAP_W'(16);

	localparam logic KIND_GET = 1'b0;
	localparam logic KIND_PUT = 1'b1;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_MATCH,
		ST_COMMIT
	} state_t;

	typedef struct packed {
		logic load;
		logic match;
		logic commit;
	} cmd_t;

	typedef struct packed {
		logic is_get;
	} status_t;

endpackage

// ===== hdl/lkvc_ctrl.sv =====
module lkvc_ctrl (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             s_tvalid,
	output logic             s_tready,
	output logic             m_tvalid,
	input  logic             m_tready,
	input  lkvc_pkg::status_t status,
	output lkvc_pkg::cmd_t    cmd
);
	import lkvc_pkg::*;

	state_t state_q;
	state_t state_d;
	logic   out_valid_q;
	logic   commit_ok;
	logic   accept;

	// A put never needs the output register, so it commits at once.
	assign commit_ok = !status.is_get || !out_valid_q || m_tready;
	assign accept    = s_tvalid && s_tready;

	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (s_tvalid) state_d = ST_MATCH;
			end
			ST_MATCH: begin
				state_d = ST_COMMIT;
			end
			ST_COMMIT: begin
				if (commit_ok) state_d = s_tvalid ? ST_MATCH : ST_IDLE;
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_comb begin
		s_tready   = 1'b0;
		cmd.match  = 1'b0;
		cmd.commit = 1'b0;
		case (state_q)
			ST_IDLE: begin
				s_tready = 1'b1;
			end
			ST_MATCH: begin
				cmd.match = 1'b1;
			end
			ST_COMMIT: begin
				cmd.commit = commit_ok;
				s_tready   = commit_ok;
			end
			default: begin
				s_tready = 1'b0;
			end
		endcase
		cmd.load = accept;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.commit && status.is_get) out_valid_q <= 1'b1;
			else if (m_tready) out_valid_q <= 1'b0;
		end
	end

	assign m_tvalid = out_valid_q;

endmodule

// ===== hdl/lkvc_dpath.sv =====
module lkvc_dpath (
	input  logic                        clk,
	input  logic                        arst_n,
	input  lkvc_pkg::cmd_t              cmd,
	output lkvc_pkg::status_t           status,
	input  logic                        in_kind,
	input  logic [lkvc_pkg::KEY_W-1:0]  in_key,
	input  logic [lkvc_pkg::VAL_W-1:0]  in_value,
	input  logic                        cfg_wr_en,
	input  logic [lkvc_pkg::CAP_W-1:0]  cfg_wr_data,
	output logic                        out_hit,
	output logic [lkvc_pkg::VAL_W-1:0]  out_value
);
	import lkvc_pkg::*;

	logic [KEY_W-1:0]  key_q   [DEPTH];
	logic [VAL_W-1:0]  val_q   [DEPTH];
	logic [SLOT_W-1:0] rank_q  [DEPTH];
	logic [DEPTH-1:0]  valid_q;
	logic [CNT_W-1:0]  count_q;
	logic [CAP_W-1:0]  cap_q;

	logic              kind_s1;
	logic [KEY_W-1:0]  key_s1;
	logic [VAL_W-1:0]  value_s1;

	logic              hit_s2;
	logic [SLOT_W-1:0] hit_slot_s2;

	logic [DEPTH-1:0]  hit_vec;
	logic              hit_any;
	logic [SLOT_W-1:0] hit_slot;

	logic [CNT_W-1:0]  cap_eff;
	logic [CNT_W-1:0]  evict_n;
	logic [DEPTH-1:0]  valid_kept;
	logic [SLOT_W-1:0] free_slot;
	logic [SLOT_W-1:0] hit_rank;
	logic [SLOT_W-1:0] top_rank;

	logic [SLOT_W-1:0] rank_d  [DEPTH];
	logic [DEPTH-1:0]  valid_d;
	logic [CNT_W-1:0]  count_d;
	logic              wr_key;
	logic              wr_val;
	logic [SLOT_W-1:0] wr_slot;

	assign status.is_get = (kind_s1 == KIND_GET);

	// Parallel compare against every held key.
	always_comb begin
		hit_slot = '0;
		for (int i = 0; i < DEPTH; i++) begin
			hit_vec[i] = valid_q[i] && (key_q[i] == key_s1);
		end
		for (int i = DEPTH - 1; i >= 0; i--) begin
			if (hit_vec[i]) hit_slot = SLOT_W'(i);
		end
		hit_any = |hit_vec;
	end

	always_comb begin
		if (cap_q == '0) cap_eff = CNT_W'(1);
		else if (cap_q > CAP_W'(DEPTH)) cap_eff = CNT_W'(DEPTH);
		else cap_eff = CNT_W'(cap_q);
	end

	// A lowered capacity can require several evictions; the oldest ranks go together.
	always_comb begin
		if (count_q >= cap_eff) evict_n = count_q - cap_eff + CNT_W'(1);
		else evict_n = '0;
		for (int i = 0; i < DEPTH; i++) begin
			valid_kept[i] = valid_q[i] && (CNT_W'(rank_q[i]) >= evict_n);
		end
		free_slot = '0;
		for (int i = DEPTH - 1; i >= 0; i--) begin
			if (!valid_kept[i]) free_slot = SLOT_W'(i);
		end
	end

	assign hit_rank = rank_q[hit_slot_s2];
	assign top_rank = SLOT_W'(count_q - CNT_W'(1));

	always_comb begin
		for (int i = 0; i < DEPTH; i++) begin
			rank_d[i] = rank_q[i];
		end
		valid_d = valid_q;
		count_d = count_q;
		wr_key  = 1'b0;
		wr_val  = 1'b0;
		wr_slot = hit_slot_s2;
		if (cmd.commit) begin
			if (hit_s2) begin
				for (int i = 0; i < DEPTH; i++) begin
					if (SLOT_W'(i) == hit_slot_s2) rank_d[i] = top_rank;
					else if (rank_q[i] > hit_rank) rank_d[i] = rank_q[i] - SLOT_W'(1);
				end
				wr_val = !status.is_get;
			end else if (!status.is_get) begin
				for (int i = 0; i < DEPTH; i++) begin
					rank_d[i] = SLOT_W'(CNT_W'(rank_q[i]) - evict_n);
				end
				rank_d[free_slot]  = SLOT_W'(count_q - evict_n);
				valid_d            = valid_kept;
				valid_d[free_slot] = 1'b1;
				count_d            = count_q - evict_n + CNT_W'(1);
				wr_key             = 1'b1;
				wr_val             = 1'b1;
				wr_slot            = free_slot;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
			count_q <= '0;
			cap_q   <= CAP_RESET;
		end else begin
			valid_q <= valid_d;
			count_q <= count_d;
			if (cfg_wr_en) cap_q <= cfg_wr_data;
		end
	end

	always_ff @(posedge clk) begin
		for (int i = 0; i < DEPTH; i++) begin
			rank_q[i] <= rank_d[i];
		end
		if (wr_key) key_q[wr_slot] <= key_s1;
		if (wr_val) val_q[wr_slot] <= value_s1;
		if (cmd.load) begin
			kind_s1  <= in_kind;
			key_s1   <= in_key;
			value_s1 <= in_value;
		end
		if (cmd.match) begin
			hit_s2      <= hit_any;
			hit_slot_s2 <= hit_slot;
		end
		if (cmd.commit && status.is_get) begin
			out_hit   <= hit_s2;
			out_value <= hit_s2 ? val_q[hit_slot_s2] : '1;
		end
	end

endmodule

// ===== hdl/lru_key_value_cache.sv =====
// Fully associative key-value cache of sixteen entries with least-recently-used
// replacement. A get word (tuser 0) returns one output word: tuser is the hit flag
// and tdata the stored value, or all ones on a miss. A put word (tuser 1) returns
// nothing; it updates a present key or inserts a new one, evicting the oldest
// entries when the number held reaches the capacity register (0 acts as 1,
// above 16 acts as 16). Each word passes the parallel compare of all keys and then
// the recency and entry update, and the next word is taken
// in the update cycle. A get waits in the update cycle only while the previous
// result is still held unread in the output register. There is no clearing pass
// after reset. The capacity register should be written only while the cache is idle.
module lru_key_value_cache (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       s_tvalid,
	output logic                       s_tready,
	input  logic [63:0]                s_tdata,  // [31:0] lookup_key, [63:32] store_value
	input  logic                       s_tuser,  // [0] kind
	output logic                       m_tvalid,
	input  logic                       m_tready,
	output logic [31:0]                m_tdata,  // [31:0] read_value
	output logic                       m_tuser,  // [0] hit
	input  logic                       cfg_wr_en,
	input  logic [lkvc_pkg::CAP_W-1:0] cfg_wr_data
);
	import lkvc_pkg::*;

	cmd_t    cmd;
	status_t status;

	lkvc_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.status   (status),
		.cmd      (cmd)
	);

	lkvc_dpath u_dpath (
		.clk         (clk),
		.arst_n      (arst_n),
		.cmd         (cmd),
		.status      (status),
		.in_kind     (s_tuser),
		.in_key      (s_tdata[KEY_W-1:0]),
		.in_value    (s_tdata[KEY_W+VAL_W-1:KEY_W]),
		.cfg_wr_en   (cfg_wr_en),
		.cfg_wr_data (cfg_wr_data),
		.out_hit     (m_tuser),
		.out_value   (m_tdata)
	);

endmodule

// ===== hdl/lkvc_check.sv =====
module lkvc_check (
	input logic        clk,
	input logic        arst_n,
	input logic        s_tvalid,
	input logic        s_tready,
	input logic        s_tuser,
	input logic        m_tvalid,
	input logic        m_tready,
	input logic [31:0] m_tdata,
	input logic        m_tuser
);

	// A held result must not change under back-pressure.
	assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
		else $error("output word changed while stalled");

	// A miss always reports all ones.
	assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tuser |-> m_tdata == 32'hFFFF_FFFF)
		else $error("miss did not return all ones");

	// The cache compares keys in the cycle after accepting a word.
	assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready |=> !s_tready)
		else $error("input taken during the compare cycle");

	// A fresh result follows an accepted get through the compare and update states,
	// after which the output register shows it.
	assert property (@(posedge clk) disable iff (!arst_n)
		$rose(m_tvalid) |-> $past(s_tvalid && s_tready && !s_tuser, 3))
		else $error("output word without a get");

endmodule

bind lru_key_value_cache lkvc_check u_lkvc_check (
	.clk      (clk),
	.arst_n   (arst_n),
	.s_tvalid (s_tvalid),
	.s_tready (s_tready),
	.s_tuser  (s_tuser),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata),
	.m_tuser  (m_tuser)
);

// ===== tb/sv/tb.sv =====
module tb;
	timeunit 1ns;
	timeprecision 1ps;

	import lkvc_pkg::*;

	localparam int unsigned LIMIT_CYCLES  = 200000;
	localparam int unsigned SETTLE_CYCLES = 8;
	localparam int unsigned PHASES        = 8;
	localparam int unsigned PHASE_WORDS   = 88;
	localparam int unsigned POOL_SIZE     = 24;

	typedef struct packed {
		logic             hit;
		logic [VAL_W-1:0] read_value;
	} lookup_result_t;

	class cache_scoreboard;
		logic [KEY_W-1:0] slot_key [DEPTH];
		logic [VAL_W-1:0] slot_value [DEPTH];
		bit               slot_used [DEPTH];
		// Slot numbers of the held entries, least recently used first.
		int unsigned      recency [DEPTH];
		int unsigned      held;
		int unsigned      capacity;
		lookup_result_t   pending [$];
		int unsigned      failures;
		int unsigned      lookups;
		int unsigned      hits;
		int unsigned      stores;
		int unsigned      evictions;

		function new();
			foreach (slot_used[i])
				slot_used[i] = 1'b0;
			held      = 0;
			capacity  = DEPTH;
			failures  = 0;
			lookups   = 0;
			hits      = 0;
			stores    = 0;
			evictions = 0;
		endfunction

		function void set_capacity(logic [CAP_W-1:0] raw);
			if (raw == 0) begin
				capacity = 1;
			end else if (raw > DEPTH) begin
				capacity = DEPTH;
			end else begin
				capacity = raw;
			end
		endfunction

		function int unsigned find_position(logic [KEY_W-1:0] key);
			for (int unsigned i = 0; i < held; i++)
				if (slot_used[recency[i]] && slot_key[recency[i]] == key)
					return i;
			return held;
		endfunction

		function void remove_position(int unsigned pos);
			for (int unsigned i = pos; i + 1 < held; i++)
				recency[i] = recency[i + 1];
			held--;
		endfunction

		function void make_recent(int unsigned pos);
			int unsigned slot;
			slot = recency[pos];
			remove_position(pos);
			recency[held] = slot;
			held++;
		endfunction

		function void note_word(logic kind, logic [KEY_W-1:0] key, logic [VAL_W-1:0] value);
			int unsigned    pos;
			int unsigned    slot;
			lookup_result_t res;
			pos = find_position(key);
			if (kind == KIND_GET) begin
				lookups++;
				if (pos < held) begin
					res.hit        = 1'b1;
					res.read_value = slot_value[recency[pos]];
					hits++;
					make_recent(pos);
				end else begin
					res.hit        = 1'b0;
					res.read_value = '1;
				end
				pending = {pending, res};
			end else begin
				stores++;
				if (pos < held) begin
					slot_value[recency[pos]] = value;
					make_recent(pos);
				end else begin
					// A new key first evicts down to below the capacity, which may take
					// several entries after the capacity has been lowered.
					while (held > 0 && held >= capacity) begin
						slot_used[recency[0]] = 1'b0;
						remove_position(0);
						evictions++;
					end
					slot = 0;
					while (slot < DEPTH && slot_used[slot])
						slot++;
					if (slot < DEPTH && held < DEPTH) begin
						slot_key[slot]   = key;
						slot_value[slot] = value;
						slot_used[slot]  = 1'b1;
						recency[held]    = slot;
						held++;
					end
				end
			end
		endfunction

		function void check_word(logic hit, logic [VAL_W-1:0] value);
			lookup_result_t exp;
			if (pending.size() == 0) begin
				$error("unexpected read word: hit %0b, read_value %h", hit, value);
				failures++;
			end else begin
				exp = pending.pop_front();
				if (hit !== exp.hit) begin
					$error("hit: expected %0b, actual %0b", exp.hit, hit);
					failures++;
				end
				if (value !== exp.read_value) begin
					$error("read_value: expected %h, actual %h", exp.read_value, value);
					failures++;
				end
			end
		endfunction
	endclass

	logic              clk         = 1'b0;
	logic              arst_n      = 1'b0;
	logic              s_tvalid    = 1'b0;
	logic              s_tready;
	logic [63:0]       s_tdata     = '0;  // [31:0] lookup_key, [63:32] store_value
	logic              s_tuser     = 1'b0;  // [0] kind
	logic              m_tvalid;
	logic              m_tready    = 1'b0;
	logic [31:0]       m_tdata;  // [31:0] read_value
	logic              m_tuser;  // [0] hit
	logic              cfg_wr_en   = 1'b0;
	logic [CAP_W-1:0]  cfg_wr_data = '0;

	cache_scoreboard   sb = new();
	int unsigned       send_idle_pct  = 0;
	int unsigned       recv_stall_pct = 0;
	int unsigned       cap_writes     = 0;
	int unsigned       cycle_count    = 0;
	int unsigned       phase_caps [PHASES] = '{16, 1, 3, 31, 0, 17, 8, 2};
	int unsigned       idle_plan [4]       = '{0, 64, 0, 37};
	int unsigned       stall_plan [4]      = '{0, 0, 64, 37};

	lru_key_value_cache u_top (
		.clk        (clk),
		.arst_n     (arst_n),
		.s_tvalid   (s_tvalid),
		.s_tready   (s_tready),
		.s_tdata    (s_tdata),
		.s_tuser    (s_tuser),
		.m_tvalid   (m_tvalid),
		.m_tready   (m_tready),
		.m_tdata    (m_tdata),
		.m_tuser    (m_tuser),
		.cfg_wr_en  (cfg_wr_en),
		.cfg_wr_data(cfg_wr_data)
	);

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	always @(posedge clk) begin
		if (m_tvalid && m_tready)
			sb.check_word(m_tuser, m_tdata);
		m_tready <= ($urandom_range(99) >= recv_stall_pct);
	end

	initial begin
		while (cycle_count < LIMIT_CYCLES) begin
			@(posedge clk);
			cycle_count++;
		end
		$display("Verification failed");
		$finish;
	end

	task automatic send_word(input logic kind, input logic [KEY_W-1:0] key,
			input logic [VAL_W-1:0] value);
		while ($urandom_range(99) < send_idle_pct) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser  <= kind;
		s_tdata  <= {value, key};
		do
			@(posedge clk);
		while (!s_tready);
		sb.note_word(kind, key, value);
	endtask

	// A put leaves no read word behind, so the cache may still be busy when the
	// last lookup has returned; the task then idles on to cover the update stage.
	task automatic settle_idle();
		s_tvalid <= 1'b0;
		while (sb.pending.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_capacity(input logic [CAP_W-1:0] raw);
		settle_idle();
		cfg_wr_en   <= 1'b1;
		cfg_wr_data <= raw;
		@(posedge clk);
		cfg_wr_en <= 1'b0;
		sb.set_capacity(raw);
		cap_writes++;
	endtask

	initial begin
		logic [KEY_W-1:0] key_pool [POOL_SIZE];
		logic [KEY_W-1:0] key;
		int unsigned      span;

		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		foreach (key_pool[i])
			key_pool[i] = $urandom;

		// Extreme keys and values, a stored value of all ones, and an update.
		send_word(KIND_GET, 32'h0000_0000, $urandom);
		send_word(KIND_PUT, 32'h8000_0000, 32'h7FFF_FFFF);
		send_word(KIND_PUT, 32'h7FFF_FFFF, 32'h8000_0000);
		send_word(KIND_PUT, 32'h0000_0000, 32'h0000_0000);
		send_word(KIND_PUT, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
		send_word(KIND_GET, 32'h8000_0000, $urandom);
		send_word(KIND_GET, 32'h7FFF_FFFF, $urandom);
		send_word(KIND_GET, 32'hFFFF_FFFF, $urandom);
		send_word(KIND_PUT, 32'h0000_0000, 32'h1234_5678);
		send_word(KIND_GET, 32'h0000_0000, $urandom);
		send_word(KIND_GET, 32'h0000_0001, $urandom);

		// A capacity of zero acts as one and sits below the four entries held:
		// lookups still see them all, and the next new key clears them out.
		write_capacity(0);
		send_word(KIND_GET, 32'h8000_0000, $urandom);
		send_word(KIND_PUT, 32'h5555_5555, 32'hAAAA_AAAA);
		send_word(KIND_GET, 32'h0000_0000, $urandom);
		send_word(KIND_GET, 32'h5555_5555, $urandom);

		// A touched entry survives while the untouched one is evicted.
		write_capacity(2);
		send_word(KIND_PUT, 32'hAAAA_AAAA, 32'h5555_5555);
		send_word(KIND_PUT, 32'h0F0F_0F0F, 32'hF0F0_F0F0);
		send_word(KIND_GET, 32'hAAAA_AAAA, $urandom);
		send_word(KIND_PUT, 32'hF0F0_F0F0, 32'h0F0F_0F0F);
		send_word(KIND_GET, 32'h0F0F_0F0F, $urandom);
		send_word(KIND_GET, 32'hAAAA_AAAA, $urandom);

		for (int unsigned p = 0; p < PHASES; p++) begin
			write_capacity(phase_caps[p][CAP_W-1:0]);
			send_idle_pct  = idle_plan[p % 4];
			recv_stall_pct = stall_plan[p % 4];
			repeat (4) key_pool[$urandom_range(POOL_SIZE - 1)] = $urandom;
			// Keys mostly come from a pool a little larger than the capacity, so
			// that hits, updates and evictions all happen often.
			span = sb.capacity + 4;
			repeat (PHASE_WORDS) begin
				if ($urandom_range(99) < 15)
					key = $urandom;
				else
					key = key_pool[$urandom_range(span - 1)];
				send_word($urandom_range(1) ? KIND_PUT : KIND_GET, key, $urandom);
			end
		end

		send_idle_pct  = 0;
		recv_stall_pct = 0;
		settle_idle();

		$display("Run covered %0d lookups (%0d hits) and %0d puts with %0d evictions,",
			sb.lookups, sb.hits, sb.stores, sb.evictions);
		$display("across %0d capacity writes and four idling patterns.", cap_writes);
		if (sb.failures == 0 && sb.pending.size() == 0) begin
			$display("Verification passed");
		end else begin
			$display("Verification failed");
		end
		$finish;
	end

endmodule

// ===== sim.f =====
hdl/lkvc_pkg.sv
hdl/lkvc_ctrl.sv
hdl/lkvc_dpath.sv
hdl/lru_key_value_cache.sv
hdl/lkvc_check.sv
tb/sv/tb.sv
